[rtl/cefe_pkg.sv]
// ============================================================================
// cefe_pkg
// Shared types and constants of the crystal event feature extractor.
// ============================================================================
package cefe_pkg;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 272;
    localparam int unsigned ADDR_W     = 4;

    localparam logic [5:0]  CONTACT_CHANNEL   = 6'd9;
    localparam logic [23:0] NO_CONTACT_ENERGY = 24'hFF_FFF0;
    localparam logic [6:0]  HIT_MAX           = 7'd127;
    localparam logic [3:0]  RING_SAT          = 4'd7;
    localparam logic [47:0] STAMP_ONES        = 48'hFFFF_FFFF_FFFF;
    // Multiplying by 43 and dropping 8 bits divides any 6-bit segment by six.
    localparam logic [5:0]  RING_RECIP        = 6'd43;

    typedef enum logic [1:0] {
        REG_ENERGY_THRESHOLD = 2'd0,
        REG_TIME_WINDOW_LOW  = 2'd1,
        REG_TIME_WINDOW_HIGH = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic signed [23:0] energy_threshold;
        logic signed [15:0] time_window_low;
        logic signed [15:0] time_window_high;
    } t_cfg;

    typedef struct packed {
        logic [5:0]         channel_number;
        logic [5:0]         segment_number;
        logic signed [23:0] segment_energy;
        logic signed [15:0] channel_time;
        logic [47:0]        stamp;
        logic               last_channel;
    } t_item;

    typedef struct packed {
        logic signed [29:0] sum_above_threshold;
        logic signed [29:0] sum_in_window;
        logic [6:0]         segments_hit;
        logic [22:0]        peak_energy;
        logic [5:0]         peak_segment;
        logic               peak_valid;
        logic [2:0]         deepest_ring;
        logic [47:0]        earliest_stamp;
        logic [47:0]        latest_stamp;
        logic [47:0]        stamp_span;
        logic signed [23:0] contact_energy;
        logic               contact_found;
    } t_result;

endpackage

[rtl/cefe_accum.sv]
// ============================================================================
// cefe_accum
// Per-event accumulators and the summary built from their next values.
// ============================================================================
module cefe_accum
    import cefe_pkg::*;
#(
    parameter int unsigned SEGMENT_COUNT = 36
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_step,
    output t_result o_result
);

    localparam logic [5:0] SEG_LIMIT = 6'(SEGMENT_COUNT);

    logic signed [29:0] r_sum, n_sum;
    logic signed [29:0] r_win, n_win;
    logic [6:0]         r_hits, n_hits;
    logic signed [23:0] r_best, n_best;
    logic [5:0]         r_best_seg, n_best_seg;
    logic               r_best_seen, n_best_seen;
    logic [2:0]         r_ring, n_ring;
    logic [47:0]        r_low, n_low;
    logic [47:0]        r_high, n_high;
    logic signed [23:0] r_cc, n_cc;
    logic               r_cc_seen, n_cc_seen;

    logic               w_is_seg;
    logic               w_hit;
    logic               w_in_win;
    logic [11:0]        w_prod;
    logic [3:0]         w_ring_raw;
    logic [2:0]         w_ring;
    logic signed [30:0] w_sum_ext;
    logic signed [30:0] w_win_ext;

    function automatic logic signed [29:0] sat30(input logic signed [30:0] v);
        logic signed [29:0] r;
        if (v[30] != v[29]) begin
            r = v[30] ? {1'b1, 29'd0} : {1'b0, {29{1'b1}}};
        end else begin
            r = v[29:0];
        end
        return r;
    endfunction

    always_comb begin
        w_is_seg   = i_item.segment_number < SEG_LIMIT;
        w_hit      = w_is_seg && (i_item.segment_energy > i_cfg.energy_threshold);
        w_in_win   = (i_item.channel_time > i_cfg.time_window_low)
                  && (i_item.channel_time < i_cfg.time_window_high);
        w_prod     = 12'(i_item.segment_number) * 12'(RING_RECIP);
        w_ring_raw = w_prod[11:8] + 4'd1;
        w_ring     = (w_ring_raw > RING_SAT) ? RING_SAT[2:0] : w_ring_raw[2:0];
        w_sum_ext  = 31'(r_sum) + 31'(i_item.segment_energy);
        w_win_ext  = 31'(r_win) + 31'(i_item.segment_energy);

        n_sum       = r_sum;
        n_win       = r_win;
        n_hits      = r_hits;
        n_ring      = r_ring;
        n_best      = r_best;
        n_best_seg  = r_best_seg;
        n_best_seen = r_best_seen;
        n_cc        = r_cc;
        n_cc_seen   = r_cc_seen;

        if (w_hit) begin
            n_sum = sat30(w_sum_ext);
            if (w_in_win) begin
                n_win = sat30(w_win_ext);
            end
            if (r_hits != HIT_MAX) begin
                n_hits = r_hits + 7'd1;
            end
            if (w_ring > r_ring) begin
                n_ring = w_ring;
            end
        end
        if (w_is_seg && (i_item.segment_energy > r_best)) begin
            n_best      = i_item.segment_energy;
            n_best_seg  = i_item.segment_number;
            n_best_seen = 1'b1;
        end
        if ((i_item.channel_number == CONTACT_CHANNEL) && !r_cc_seen) begin
            n_cc      = i_item.segment_energy;
            n_cc_seen = 1'b1;
        end
        n_low  = (i_item.stamp < r_low)  ? i_item.stamp : r_low;
        n_high = (i_item.stamp > r_high) ? i_item.stamp : r_high;

        o_result.sum_above_threshold = n_sum;
        o_result.sum_in_window       = n_win;
        o_result.segments_hit        = n_hits;
        o_result.peak_energy         = n_best[22:0];
        o_result.peak_segment        = n_best_seg;
        o_result.peak_valid          = n_best_seen;
        o_result.deepest_ring        = n_ring;
        o_result.earliest_stamp      = n_low;
        o_result.latest_stamp        = n_high;
        o_result.stamp_span          = n_high - n_low;
        o_result.contact_energy      = n_cc_seen ? n_cc : NO_CONTACT_ENERGY;
        o_result.contact_found       = n_cc_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_channel)) begin
            r_sum       <= '0;
            r_win       <= '0;
            r_hits      <= '0;
            r_best      <= '0;
            r_best_seg  <= '0;
            r_best_seen <= 1'b0;
            r_ring      <= '0;
            r_low       <= STAMP_ONES;
            r_high      <= '0;
            r_cc        <= '0;
            r_cc_seen   <= 1'b0;
        end else if (i_step) begin
            r_sum       <= n_sum;
            r_win       <= n_win;
            r_hits      <= n_hits;
            r_best      <= n_best;
            r_best_seg  <= n_best_seg;
            r_best_seen <= n_best_seen;
            r_ring      <= n_ring;
            r_low       <= n_low;
            r_high      <= n_high;
            r_cc        <= n_cc;
            r_cc_seen   <= n_cc_seen;
        end
    end

endmodule

[rtl/crystal_event_feature_extractor.sv]
// ============================================================================
// crystal_event_feature_extractor
// Builds one feature summary per detector crystal event from its channels.
// ============================================================================
// Channels of an event arrive one per transaction on the s_axis side; tlast
// marks the final channel. Each transaction is captured in an input register
// and folded into the event accumulators from there, so a new channel can be
// taken every cycle. An event's summary is registered for m_axis as its last
// channel is folded in and stays until it is taken. While a summary waits,
// channels of the next event keep flowing into the accumulators; only the
// next last channel waits in the input register, which holds s_axis_tready
// low until the output register frees. The throughput of one channel per
// cycle is set by the single accumulator update between the input register
// and the result register. The APB port writes the energy threshold and the
// time window bounds; the user must write it only while no event is in
// flight, and the block does not enforce this. Reset clears the accumulators,
// empties both registers and restores the default threshold and window.
// ============================================================================
module crystal_event_feature_extractor
    import cefe_pkg::*;
#(
    parameter int unsigned SEGMENT_COUNT = 36
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // channel_number, segment_number, segment_energy, channel_time, stamp, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sum_above_threshold, sum_in_window, segments_hit, peak_energy, peak_segment,
    // peak_valid, deepest_ring, earliest_stamp, latest_stamp, stamp_span,
    // contact_energy, contact_found, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_result;
    logic    w_step;
    logic    w_cfg_wr;
    t_item   w_item;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_threshold <= '0;
            r_cfg.time_window_low  <= 16'sh8000;
            r_cfg.time_window_high <= 16'sh7FFF;
        end else if (w_cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_ENERGY_THRESHOLD: r_cfg.energy_threshold <= pwdata[23:0];
                REG_TIME_WINDOW_LOW:  r_cfg.time_window_low  <= pwdata[15:0];
                REG_TIME_WINDOW_HIGH: r_cfg.time_window_high <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_ENERGY_THRESHOLD: prdata = {8'd0, r_cfg.energy_threshold};
            REG_TIME_WINDOW_LOW:  prdata = {16'd0, r_cfg.time_window_low};
            REG_TIME_WINDOW_HIGH: prdata = {16'd0, r_cfg.time_window_high};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        w_item.channel_number = s_axis_tdata[5:0];
        w_item.segment_number = s_axis_tdata[11:6];
        w_item.segment_energy = s_axis_tdata[35:12];
        w_item.channel_time   = s_axis_tdata[51:36];
        w_item.stamp          = s_axis_tdata[99:52];
        w_item.last_channel   = s_axis_tlast;
    end

    assign w_step = r_in_valid
                 && (!r_item.last_channel || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= w_item;
        end
    end

    cefe_accum #(
        .SEGMENT_COUNT(SEGMENT_COUNT)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_step   (w_step),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_item.last_channel) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_item.last_channel) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0,
                            r_out.contact_found,
                            r_out.contact_energy,
                            r_out.stamp_span,
                            r_out.latest_stamp,
                            r_out.earliest_stamp,
                            r_out.deepest_ring,
                            r_out.peak_valid,
                            r_out.peak_segment,
                            r_out.peak_energy,
                            r_out.segments_hit,
                            r_out.sum_in_window,
                            r_out.sum_above_threshold};

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_item.last_channel) |=> m_axis_tvalid)
        else $error("summary not presented after last channel");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_item.last_channel && r_out_valid))
        else $error("input stalled without a waiting last channel");

    a_span_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.stamp_span == r_out.latest_stamp - r_out.earliest_stamp))
        else $error("stamp span mismatch");

    a_no_hits_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.segments_hit == 7'd0))
            |-> ((r_out.sum_above_threshold == 30'sd0) && (r_out.deepest_ring == 3'd0)
                 && (r_out.sum_in_window == 30'sd0)))
        else $error("sums or ring set without hits");
`endif

endmodule
